### rtl/core/cdad_pkg.sv
// Shared types, constants and month-length function for the date adder.
package cdad_pkg;

  // Field widths
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 12;
  localparam int unsigned CountW  = 16;

  // Internal widths: day sum, year with headroom past 4095, century count
  localparam int unsigned SumW     = 17;
  localparam int unsigned YearIntW = 13;
  localparam int unsigned CentW    = 7;
  localparam int unsigned ProdW    = 2 * YearIntW;

  // year / 100 as (year * 5243) >> 19, exact for year < 8192
  localparam logic [YearIntW-1:0] CentRecip    = 13'd5243;
  localparam int unsigned         CentShift    = 19;
  localparam logic [CentW-1:0]    YearsPerCent = 7'd100;
  localparam logic [CentW-1:0]    LastRem      = 7'd99;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_RUN
  } cdad_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic calc_q;
    logic calc_r;
    logic step;
    logic emit;
  } cdad_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
  } cdad_sts_t;

  // Days in month; invalid months count as 31 days
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/cdad_if.sv
// Input and output channel interfaces for the date adder.
interface cdad_in_if;
  import cdad_pkg::*;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [CountW-1:0] day_count;

  modport source (
    output valid, start_day, start_month, start_year, day_count,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year, day_count,
    output ready
  );
endinterface

interface cdad_out_if;
  import cdad_pkg::*;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   end_day;
  logic [MonthW-1:0] end_month;
  logic [YearW-1:0]  end_year;

  modport source (
    output valid, end_day, end_month, end_year,
    input  ready
  );
  modport sink (
    input  valid, end_day, end_month, end_year,
    output ready
  );
endinterface

### rtl/core/calendar_date_add_days.sv
// Top level: Gregorian date plus day count, controller and datapath.
//
//  Channel | Dir | Payload                                       | Handshake
//  in_i    | in  | start_day, start_month, start_year, day_count | valid/ready
//  out_o   | out | end_day, end_month, end_year                  | valid/ready
//
//  One beat in gives one beat out, one item in flight at a time.
//  The subtract loop walks one month per cycle, M months in all (up to about
//  2160 for a day count of 65535), after loading and splitting the year into
//  century and remainder.
//  A new beat is taken as soon as the result sits in the output register.
//  A stalled output holds the finished result; reset clears control only.
module calendar_date_add_days (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdad_in_if.sink    in_i,
  cdad_out_if.source out_o
);
  import cdad_pkg::*;

  cdad_cmd_t cmd;
  cdad_sts_t sts;

  cdad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdad_dp u_dp (
    .clk_i         (clk_i),
    .start_day_i   (in_i.start_day),
    .start_month_i (in_i.start_month),
    .start_year_i  (in_i.start_year),
    .day_count_i   (in_i.day_count),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .end_day_o     (out_o.end_day),
    .end_month_o   (out_o.end_month),
    .end_year_o    (out_o.end_year)
  );

endmodule

### rtl/core/cdad_ctrl.sv
// Controller state machine: sequences load, century split, month walk and emit.
module cdad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cdad_pkg::cdad_sts_t  sts_i,
  output cdad_pkg::cdad_cmd_t  cmd_o
);
  import cdad_pkg::*;

  cdad_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  state_d = ST_REM;
      ST_REM:  state_d = ST_RUN;
      ST_RUN:  if (!sts_i.more && out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV:  cmd_o.calc_q = 1'b1;
      ST_REM:  cmd_o.calc_r = 1'b1;
      ST_RUN: begin
        cmd_o.step = sts_i.more;
        cmd_o.emit = !sts_i.more && out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // Result beat valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.calc_q, cmd_o.calc_r, cmd_o.step, cmd_o.emit}))
    else $error("more than one datapath command active");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before taken");

  a_accept_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DIV)
    else $error("accepted beat did not start century split");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q && state_q == ST_IDLE)
    else $error("emit did not present result");

endmodule

### rtl/core/cdad_dp.sv
// Datapath: day sum, year/century counters, month walk and result register.
module cdad_dp (
  input  logic                         clk_i,
  input  logic [cdad_pkg::DayW-1:0]    start_day_i,
  input  logic [cdad_pkg::MonthW-1:0]  start_month_i,
  input  logic [cdad_pkg::YearW-1:0]   start_year_i,
  input  logic [cdad_pkg::CountW-1:0]  day_count_i,
  input  cdad_pkg::cdad_cmd_t          cmd_i,
  output cdad_pkg::cdad_sts_t          sts_o,
  output logic [cdad_pkg::DayW-1:0]    end_day_o,
  output logic [cdad_pkg::MonthW-1:0]  end_month_o,
  output logic [cdad_pkg::YearW-1:0]   end_year_o
);
  import cdad_pkg::*;

  logic [SumW-1:0]     day_q, day_d;
  logic [MonthW-1:0]   month_q, month_d;
  logic [YearIntW-1:0] year_q, year_d;
  logic [CentW-1:0]    cent_q, cent_d;
  logic [CentW-1:0]    yr_rem_q, yr_rem_d;
  logic [DayW-1:0]     end_day_q;
  logic [MonthW-1:0]   end_month_q;
  logic [YearW-1:0]    end_year_q;

  logic [ProdW-1:0]    prod;
  logic [YearIntW-1:0] cent_yrs;
  logic [YearIntW-1:0] rem_full;
  logic                leap;
  logic [DayW-1:0]     mlen;

  // Century split: quotient by reciprocal multiply, then remainder
  assign prod     = ProdW'(year_q) * ProdW'(CentRecip);
  assign cent_yrs = YearIntW'(cent_q) * YearIntW'(YearsPerCent);
  assign rem_full = year_q - cent_yrs;

  // Leap year from low bits, remainder by 100 and century count
  assign leap = (year_q[1:0] == 2'b00) && ((yr_rem_q != '0) || (cent_q[1:0] == 2'b00));
  assign mlen = month_len(month_q, leap);

  assign sts_o.more = day_q > SumW'(mlen);

  // Register updates per command
  always_comb begin
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    cent_d   = cent_q;
    yr_rem_d = yr_rem_q;
    if (cmd_i.load) begin
      day_d   = SumW'(start_day_i) + SumW'(day_count_i);
      month_d = start_month_i;
      year_d  = YearIntW'(start_year_i);
    end
    if (cmd_i.calc_q) cent_d = prod[CentShift +: CentW];
    if (cmd_i.calc_r) yr_rem_d = rem_full[CentW-1:0];
    if (cmd_i.step) begin
      day_d = day_q - SumW'(mlen);
      if (month_q >= MonthDec) begin
        month_d = MonthJan;
        year_d  = year_q + 1'b1;
        if (yr_rem_q == LastRem) begin
          yr_rem_d = '0;
          cent_d   = cent_q + 1'b1;
        end else begin
          yr_rem_d = yr_rem_q + 1'b1;
        end
      end else begin
        month_d = month_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    day_q    <= day_d;
    month_q  <= month_d;
    year_q   <= year_d;
    cent_q   <= cent_d;
    yr_rem_q <= yr_rem_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      end_day_q   <= day_q[DayW-1:0];
      end_month_q <= month_q;
      end_year_q  <= year_q[YearW-1:0];
    end
  end

  assign end_day_o   = end_day_q;
  assign end_month_o = end_month_q;
  assign end_year_o  = end_year_q;

endmodule
